[rtl/core/hfc_pkg.sv]
package hfc_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int NODE_MAX    = 2 * MAX_SYMBOLS - 1;
   localparam int SYM_W       = $clog2(MAX_SYMBOLS);
   localparam int NODE_W      = $clog2(NODE_MAX + 1);
   localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
   localparam int WEIGHT_W    = 22;
   localparam int KEY_W       = 24;
   localparam int CODE_W      = 31;
   localparam int LEN_W       = 5;
   localparam int FREQ_W      = 16;
   localparam int CHAR_W      = 8;

   // keys above any weight, for an empty slot of the two-smallest search
   localparam logic [KEY_W-1:0] KEY_NONE1 = KEY_W'(1) << (KEY_W - 1);
   localparam logic [KEY_W-1:0] KEY_NONE2 = (KEY_W'(1) << (KEY_W - 1)) + KEY_W'(1);

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;

   localparam logic KIND_CODE   = 1'b0;
   localparam logic KIND_SYMBOL = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  k1;
      logic [KEY_W-1:0]  k2;
      logic [NODE_W-1:0] i1;
      logic [NODE_W-1:0] i2;
   } rank_type;

endpackage

[rtl/core/huffman_tree_codec.sv]
// Channel   | Ports                                   | Transfer
// ----------+-----------------------------------------+-------------------------------
// request   | start, busy, req_*                      | start high while busy low
// response  | rsp_strobe, rsp_*                       | one cycle, rsp_strobe high
//
// Load gives no response; encode answers from ST_ENC_OUT, decode from ST_DEC_OUT
// once a bit reaches a leaf; an error answers straight from idle. The build after
// the last load scans nodes 0..s-1 for each merged node s (one weight read and one
// compare/swap per cycle in hfc_rank), then merges; code derivation takes a root
// step, then a read, left and right step per internal node.
// busy stays high for all of that. Reset is synchronous, active high; it clears
// the sequencer, counts and flags; node memories are not cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.
module huffman_tree_codec
   import hfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [CHAR_W-1:0] req_symbol_char,
   input  logic [FREQ_W-1:0] req_frequency,
   input  logic [SYM_W-1:0]  req_symbol_index,
   input  logic              req_code_bit,
   input  logic              req_last,
   output logic              rsp_strobe,
   output logic              rsp_kind,
   output logic [CODE_W-1:0] rsp_code_bits,
   output logic [LEN_W-1:0]  rsp_code_length,
   output logic [CHAR_W-1:0] rsp_decoded_char,
   output logic              rsp_status
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN     = 4'd1;
   localparam logic [3:0] ST_MERGE    = 4'd2;
   localparam logic [3:0] ST_ROOT     = 4'd3;
   localparam logic [3:0] ST_DRV_RD   = 4'd4;
   localparam logic [3:0] ST_DRV_L    = 4'd5;
   localparam logic [3:0] ST_DRV_R    = 4'd6;
   localparam logic [3:0] ST_ENC_OUT  = 4'd7;
   localparam logic [3:0] ST_DEC_STEP = 4'd8;
   localparam logic [3:0] ST_DEC_OUT  = 4'd9;

   // sequencer and bookkeeping
   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                built_ff, built_in;
   logic [NODE_W-1:0]   dnode_ff, dnode_in;
   logic [NODE_W-1:0]   s_ff, s_in;         // node being created
   logic [NODE_W-1:0]   t_ff, t_in;         // node being expanded
   logic [NODE_W-1:0]   issue_ff, issue_in; // scan read pointer
   logic                pv_ff, pv_in;       // scan read in flight
   logic [NODE_W-1:0]   pidx_ff, pidx_in;
   logic [NODE_MAX-1:0] active_ff, active_in;
   logic                bit_ff, bit_in;

   // response registers
   logic              strobe_ff, strobe_in;
   logic              kind_ff, kind_in;
   logic [CODE_W-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              status_ff, status_in;

   // node memories
   logic [WEIGHT_W-1:0]     weight_mem [NODE_MAX];
   logic [NODE_W-1:0]       lchild_mem [NODE_MAX];
   logic [NODE_W-1:0]       rchild_mem [NODE_MAX];
   logic [CODE_W+LEN_W-1:0] code_mem   [NODE_MAX];
   logic [CHAR_W-1:0]       char_mem   [MAX_SYMBOLS];

   logic [WEIGHT_W-1:0]     weight_q;
   logic [NODE_W-1:0]       lchild_q, rchild_q;
   logic [CODE_W+LEN_W-1:0] code_q;
   logic [CHAR_W-1:0]       char_q;

   logic                    w_we, c_we, ch_we, cd_we;
   logic [NODE_W-1:0]       w_addr, ch_waddr, ch_raddr, cd_waddr, cd_raddr;
   logic [WEIGHT_W-1:0]     w_data;
   logic [CODE_W+LEN_W-1:0] cd_data;
   logic [SYM_W-1:0]        c_waddr, c_raddr;

   logic                    accept;
   logic [CNT_W-1:0]        n_eff, n_new;
   logic                    load_store;
   logic [NODE_W:0]         total_w;
   logic [NODE_W-1:0]       root, node_sel, next_node;
   logic                    rank_init, rank_step;
   rank_type                rank;
   logic [KEY_W-1:0]        sum;

   hfc_rank u_rank (
      .clock  (clock),
      .init   (rank_init),
      .step   (rank_step),
      .act    (active_ff[pidx_ff]),
      .weight (weight_q),
      .idx    (pidx_ff),
      .rank   (rank)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // a load after a finished build opens a new table
   assign n_eff      = built_ff ? '0 : count_ff;
   assign load_store = (n_eff < CNT_W'(MAX_SYMBOLS));
   assign n_new      = load_store ? n_eff + CNT_W'(1) : n_eff;
   assign total_w    = {count_ff, 1'b0} - (NODE_W+1)'(1);
   assign root       = NODE_W'(total_w - (NODE_W+1)'(1));
   assign node_sel   = ((dnode_ff >= NODE_W'(NODE_MAX)) || ({1'b0, dnode_ff} < count_ff))
                       ? root : dnode_ff;
   assign next_node  = bit_ff ? rchild_q : lchild_q;
   assign sum        = rank.k1 + rank.k2;

   assign ch_raddr = (state_ff == ST_IDLE) ? node_sel : t_ff;
   assign cd_raddr = (state_ff == ST_IDLE) ? NODE_W'(req_symbol_index) : t_ff;
   assign c_raddr  = (state_ff == ST_IDLE) ? '0 : next_node[SYM_W-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      built_in  = built_ff;
      dnode_in  = dnode_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      issue_in  = issue_ff;
      pv_in     = 1'b0;
      pidx_in   = pidx_ff;
      active_in = active_ff;
      bit_in    = bit_ff;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      bits_in   = '0;
      len_in    = '0;
      char_in   = '0;
      status_in = STATUS_OK;
      rank_init = 1'b0;
      rank_step = 1'b0;
      w_we      = 1'b0;
      w_addr    = s_ff;
      w_data    = sum[WEIGHT_W-1:0];
      c_we      = 1'b0;
      c_waddr   = n_eff[SYM_W-1:0];
      ch_we     = 1'b0;
      ch_waddr  = s_ff;
      cd_we     = 1'b0;
      cd_waddr  = root;
      cd_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_LOAD: begin
                     if (built_ff) begin
                        built_in = 1'b0;
                        dnode_in = '0;
                     end
                     count_in = n_new;
                     if (load_store) begin
                        w_we   = 1'b1;
                        w_addr = NODE_W'(n_eff);
                        w_data = WEIGHT_W'(req_frequency);
                        c_we   = 1'b1;
                     end
                     if (req_last && (n_new != '0)) begin
                        for (int i = 0; i < NODE_MAX; i++) begin
                           active_in[i] = (i < int'(n_new));
                        end
                        s_in = NODE_W'(n_new);
                        if (n_new > CNT_W'(1)) begin
                           state_in  = ST_SCAN;
                           rank_init = 1'b1;
                           issue_in  = '0;
                        end else begin
                           state_in = ST_ROOT;
                        end
                     end
                  end
                  CMD_ENCODE: begin
                     if (!built_ff || ({1'b0, req_symbol_index} >= count_ff)) begin
                        strobe_in = 1'b1;
                        kind_in   = KIND_CODE;
                        status_in = STATUS_ERR;
                     end else begin
                        state_in = ST_ENC_OUT;
                     end
                  end
                  CMD_DECODE: begin
                     if (!built_ff) begin
                        strobe_in = 1'b1;
                        kind_in   = KIND_SYMBOL;
                        status_in = STATUS_ERR;
                     end else if (count_ff == CNT_W'(1)) begin
                        // lone leaf is its own root: every bit yields it
                        dnode_in = '0;
                        state_in = ST_DEC_OUT;
                     end else begin
                        bit_in   = req_code_bit;
                        state_in = ST_DEC_STEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < s_ff) begin
               pv_in    = 1'b1;
               pidx_in  = issue_ff;
               issue_in = issue_ff + NODE_W'(1);
            end
            rank_step = pv_ff;
            if (pv_ff && (pidx_ff == s_ff - NODE_W'(1))) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            w_we  = 1'b1;
            ch_we = 1'b1;
            active_in[rank.i1] = 1'b0;
            active_in[rank.i2] = 1'b0;
            active_in[s_ff]    = 1'b1;
            s_in = s_ff + NODE_W'(1);
            if ({1'b0, s_ff} + (NODE_W+1)'(1) < total_w) begin
               state_in  = ST_SCAN;
               rank_init = 1'b1;
               issue_in  = '0;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cd_we = 1'b1;
            t_in  = root;
            if (root == '0) begin
               built_in = 1'b1;
               dnode_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DRV_RD;
            end
         end
         ST_DRV_RD: begin
            state_in = ST_DRV_L;
         end
         ST_DRV_L: begin
            cd_we    = 1'b1;
            cd_waddr = lchild_q;
            cd_data  = {code_q[CODE_W+LEN_W-2:LEN_W], 1'b0, code_q[LEN_W-1:0] + LEN_W'(1)};
            state_in = ST_DRV_R;
         end
         ST_DRV_R: begin
            cd_we    = 1'b1;
            cd_waddr = rchild_q;
            cd_data  = {code_q[CODE_W+LEN_W-2:LEN_W], 1'b1, code_q[LEN_W-1:0] + LEN_W'(1)};
            if ({1'b0, t_ff} == count_ff) begin
               built_in = 1'b1;
               dnode_in = root;
               state_in = ST_IDLE;
            end else begin
               t_in     = t_ff - NODE_W'(1);
               state_in = ST_DRV_RD;
            end
         end
         ST_ENC_OUT: begin
            strobe_in = 1'b1;
            kind_in   = KIND_CODE;
            bits_in   = code_q[CODE_W+LEN_W-1:LEN_W];
            len_in    = code_q[LEN_W-1:0];
            state_in  = ST_IDLE;
         end
         ST_DEC_STEP: begin
            if ({1'b0, next_node} < (NODE_W+1)'(count_ff)) begin
               dnode_in = root;
               state_in = ST_DEC_OUT;
            end else begin
               dnode_in = next_node;
               state_in = ST_IDLE;
            end
         end
         ST_DEC_OUT: begin
            strobe_in = 1'b1;
            kind_in   = KIND_SYMBOL;
            char_in   = char_q;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         built_ff  <= 1'b0;
         dnode_ff  <= '0;
         active_ff <= '0;
         pv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         built_ff  <= built_in;
         dnode_ff  <= dnode_in;
         active_ff <= active_in;
         pv_ff     <= pv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      t_ff      <= t_in;
      issue_ff  <= issue_in;
      pidx_ff   <= pidx_in;
      bit_ff    <= bit_in;
      kind_ff   <= kind_in;
      bits_ff   <= bits_in;
      len_ff    <= len_in;
      char_ff   <= char_in;
      status_ff <= status_in;
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_addr] <= w_data;
      end
      weight_q <= weight_mem[issue_ff];
   end

   always_ff @(posedge clock) begin
      if (ch_we) begin
         lchild_mem[ch_waddr] <= rank.i2;
         rchild_mem[ch_waddr] <= rank.i1;
      end
      lchild_q <= lchild_mem[ch_raddr];
      rchild_q <= rchild_mem[ch_raddr];
   end

   always_ff @(posedge clock) begin
      if (cd_we) begin
         code_mem[cd_waddr] <= cd_data;
      end
      code_q <= code_mem[cd_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         char_mem[c_waddr] <= req_symbol_char;
      end
      char_q <= char_mem[c_raddr];
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_code_bits    = bits_ff;
   assign rsp_code_length  = len_ff;
   assign rsp_decoded_char = char_ff;
   assign rsp_status       = status_ff;

endmodule

[rtl/core/hfc_rank.sv]
// Shared compare/swap unit: keeps the smallest and second smallest active node.
module hfc_rank
   import hfc_pkg::*;
(
   input  logic                clock,
   input  logic                init,
   input  logic                step,
   input  logic                act,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [NODE_W-1:0]   idx,
   output rank_type            rank
);

   rank_type rank_ff, rank_in, mid;

   always_comb begin
      mid = rank_ff;
      if (act && ({2'b00, weight} < rank_ff.k2)) begin
         mid.k2 = {2'b00, weight};
         mid.i2 = idx;
      end
      rank_in = mid;
      if (mid.k2 < mid.k1) begin
         rank_in.k1 = mid.k2;
         rank_in.k2 = mid.k1;
         rank_in.i1 = mid.i2;
         rank_in.i2 = mid.i1;
      end
   end

   always_ff @(posedge clock) begin
      if (init) begin
         rank_ff.k1 <= KEY_NONE1;
         rank_ff.k2 <= KEY_NONE2;
         rank_ff.i1 <= '0;
         rank_ff.i2 <= '0;
      end else if (step) begin
         rank_ff <= rank_in;
      end
   end

   assign rank = rank_ff;

endmodule

[rtl/core/hfc_checker.sv]
module hfc_checker
   import hfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_command,
   input  logic              rsp_strobe,
   input  logic              rsp_kind,
   input  logic [CODE_W-1:0] rsp_code_bits,
   input  logic [LEN_W-1:0]  rsp_code_length,
   input  logic [CHAR_W-1:0] rsp_decoded_char,
   input  logic              rsp_status
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("busy or strobe after reset");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_LOAD) |=> !rsp_strobe)
      else $error("load produced a response");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |->
         (rsp_code_bits == '0) && (rsp_code_length == '0) && (rsp_decoded_char == '0))
      else $error("error response carries payload");

   a_code_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == KIND_CODE) |->
         ((rsp_code_bits >> rsp_code_length) == '0) && (rsp_decoded_char == '0))
      else $error("code bits beyond code length");

endmodule

bind huffman_tree_codec hfc_checker u_hfc_checker (.*);
